>>> rtl/core/resource_allocator_with_wait_lists_assert.svh
// Assertion macros used by the resource allocator RTL.
`ifndef RESOURCE_ALLOCATOR_WITH_WAIT_LISTS_ASSERT_SVH
`define RESOURCE_ALLOCATOR_WITH_WAIT_LISTS_ASSERT_SVH
// Condition holds in the same cycle as the trigger.
`define RAWL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Condition holds in the cycle after the trigger.
`define RAWL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> rtl/core/rawl_pkg.sv
// Shared types and constants of the resource allocator.
package rawl_pkg;

   localparam int NUM_TYPES_DEF  = 16;
   localparam int NUM_PROCS_DEF  = 16;
   localparam int COUNT_BITS_DEF = 8;

   localparam int CMD_W      = 3;
   localparam int PROC_FW    = 4;
   localparam int TYPE_FW    = 4;
   localparam int AMT_FW     = 8;
   localparam int SLOT_FW    = 4;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   localparam logic [CMD_W-1:0] CMD_SET_COUNT   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOCATE    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RELEASE_ALL = 3'd3;
   localparam logic [CMD_W-1:0] CMD_PICK_WAITER = 3'd4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_HELD,
      ST_SCAN,
      ST_PICK,
      ST_RALL,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic want_valid;
   } scan_req_type;

   typedef struct packed {
      logic done;
      logic found;
   } scan_rsp_type;

endpackage

>>> rtl/core/resource_allocator_with_wait_lists.sv
// Counting resource manager with per-type wait lists on a request/response stream.
// Requests enter on req_ (tuser = command, tdata = process, type, amount) and
// each request gives exactly one response on rsp_. Commands: set a type's free
// count, allocate, release, release all, and pick waiter.
// An allocate that joins a wait list and pick waiter use the slot scanner, which
// tests one slot per cycle, and release all walks the holdings memory one type
// per cycle. One request is worked on at a time.
// After reset the holdings memory is cleared one entry per cycle, and req_tready
// stays low meanwhile.
// A finished response sits in an output register, so the next request is
// accepted while rsp_tready is low; that request then waits for the register
// to drain before its own response is loaded.
module resource_allocator_with_wait_lists #(
   parameter int NUM_TYPES  = rawl_pkg::NUM_TYPES_DEF,
   parameter int NUM_PROCS  = rawl_pkg::NUM_PROCS_DEF,
   parameter int COUNT_BITS = rawl_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [3:0] process, [7:4] resource_type, [15:8] amount
   input  logic [rawl_pkg::REQ_DATA_W-1:0] req_tdata,
   // [2:0] command
   input  logic [rawl_pkg::CMD_W-1:0]      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] granted, [1] waiter_found, [5:2] waiter_slot, [9:6] waiter_process,
   // [17:10] waiter_amount, [18] error, [26:19] free_after, [31:27] zero
   output logic [rawl_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import rawl_pkg::*;

   localparam int TYPE_W     = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
   localparam int PROC_W     = $clog2(NUM_PROCS);
   localparam int SLOT_W     = $clog2(NUM_PROCS);
   localparam int HELD_DEPTH = NUM_TYPES * NUM_PROCS;
   localparam int HADDR_W    = $clog2(HELD_DEPTH);
   localparam int CNT_W      = $clog2(NUM_TYPES + 1);
   localparam int SUM_W      = ((COUNT_BITS > AMT_FW) ? COUNT_BITS : AMT_FW) + 1;
   localparam logic [SUM_W-1:0] CMAX = SUM_W'((1 << COUNT_BITS) - 1);

   function automatic logic [HADDR_W-1:0] held_addr(input logic [PROC_W-1:0] p,
                                                    input logic [TYPE_W-1:0] t);
      held_addr = HADDR_W'(int'(p) * NUM_TYPES + int'(t));
   endfunction

   function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
      slot_next = (s == SLOT_W'(NUM_PROCS - 1)) ? '0 : s + 1'b1;
   endfunction

   state_type state_ff, state_in;

   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [PROC_FW-1:0] p_ff, p_in;
   logic [TYPE_FW-1:0] t_ff, t_in;
   logic [AMT_FW-1:0]  amt_ff, amt_in;

   logic               granted_ff, granted_in;
   logic               found_ff, found_in;
   logic               err_ff, err_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [PROC_FW-1:0] wproc_ff, wproc_in;
   logic [AMT_FW-1:0]  wamt_ff, wamt_in;

   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [HADDR_W-1:0] clr_ff, clr_in;

   logic [COUNT_BITS-1:0] free_ff [NUM_TYPES];
   logic [NUM_PROCS-1:0]  wv_ff [NUM_TYPES];
   logic [SLOT_W-1:0]     cur_ff [NUM_TYPES];

   logic [COUNT_BITS-1:0] held_mem [HELD_DEPTH];
   logic [COUNT_BITS-1:0] held_rd_ff;
   logic [PROC_FW-1:0]    wproc_mem [NUM_TYPES][NUM_PROCS];
   logic [AMT_FW-1:0]     wamt_mem [NUM_TYPES][NUM_PROCS];
   logic [PROC_FW-1:0]    wproc_rd_ff [NUM_PROCS];
   logic [AMT_FW-1:0]     wamt_rd_ff [NUM_PROCS];

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_load;

   logic                  t_ok, p_ok;
   logic [TYPE_W-1:0]     t_ix, prev_ix;
   logic [PROC_W-1:0]     p_ix;
   logic [HADDR_W-1:0]    haddr_pt;
   logic [SUM_W-1:0]      amt_ext, free_ext, held_ext, rel_ext;
   logic [SUM_W-1:0]      add_a, add_b, add_sum, add_sat;
   logic [COUNT_BITS-1:0] sat_cnt;

   logic                  free_we, held_we, wv_set, wv_clr, wait_we, cur_we;
   logic [TYPE_W-1:0]     free_waddr, row_raddr;
   logic [COUNT_BITS-1:0] free_wdata, held_wdata;
   logic [HADDR_W-1:0]    held_waddr, held_raddr;
   logic [NUM_PROCS-1:0]  clr_mask;
   logic [AMT_FW-1:0]     free_after;

   scan_req_type          scan_req;
   scan_rsp_type          scan_rsp;
   logic [SLOT_W-1:0]     start_slot, hit_slot;

   rawl_scan #(
      .NUM_SLOTS (NUM_PROCS),
      .SLOT_W    (SLOT_W)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .scan_req   (scan_req),
      .start_slot (start_slot),
      .valid_row  (wv_ff[t_ix]),
      .scan_rsp   (scan_rsp),
      .hit_slot   (hit_slot)
   );

   assign t_ok     = int'(t_ff) < NUM_TYPES;
   assign p_ok     = int'(p_ff) < NUM_PROCS;
   assign t_ix     = TYPE_W'(t_ff);
   assign p_ix     = PROC_W'(p_ff);
   assign prev_ix  = TYPE_W'(cnt_ff - 1'b1);
   assign haddr_pt = held_addr(p_ix, t_ix);
   assign amt_ext  = SUM_W'(amt_ff);
   assign free_ext = SUM_W'(free_ff[t_ix]);
   assign held_ext = SUM_W'(held_rd_ff);
   assign rel_ext  = (amt_ext > held_ext) ? held_ext : amt_ext;

   // The one saturating adder, shared by allocate, release and release all.
   assign add_sum = add_a + add_b;
   assign add_sat = (add_sum > CMAX) ? CMAX : add_sum;
   assign sat_cnt = COUNT_BITS'(add_sat);

   // Slots of the swept type that hold the releasing process.
   always_comb begin
      for (int k = 0; k < NUM_PROCS; k++) begin
         clr_mask[k] = wv_ff[prev_ix][k] && (wproc_rd_ff[k] == p_ff);
      end
   end

   // A type out of range, or a process out of range on allocate, release or release all, reports a zero free count.
   always_comb begin
      free_after = '0;
      if (t_ok && !(!p_ok && (cmd_ff == CMD_ALLOCATE || cmd_ff == CMD_RELEASE ||
                              cmd_ff == CMD_RELEASE_ALL))) begin
         free_after = AMT_FW'(free_ff[t_ix]);
      end
   end

   always_comb begin
      rsp_data_in = {5'b0, free_after, err_ff, wamt_ff, wproc_ff, SLOT_FW'(slot_ff),
                     found_ff, granted_ff};
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      p_in       = p_ff;
      t_in       = t_ff;
      amt_in     = amt_ff;
      granted_in = granted_ff;
      found_in   = found_ff;
      err_in     = err_ff;
      slot_in    = slot_ff;
      wproc_in   = wproc_ff;
      wamt_in    = wamt_ff;
      cnt_in     = cnt_ff;
      clr_in     = clr_ff;
      free_we    = 1'b0;
      free_waddr = t_ix;
      free_wdata = sat_cnt;
      held_we    = 1'b0;
      held_waddr = haddr_pt;
      held_wdata = '0;
      held_raddr = haddr_pt;
      row_raddr  = t_ix;
      wv_set     = 1'b0;
      wv_clr     = 1'b0;
      wait_we    = 1'b0;
      cur_we     = 1'b0;
      scan_req   = '0;
      start_slot = '0;
      add_a      = '0;
      add_b      = '0;
      rsp_load   = 1'b0;
      req_tready = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            held_we    = 1'b1;
            held_waddr = clr_ff;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == HADDR_W'(HELD_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in     = req_tuser;
               p_in       = req_tdata[PROC_FW-1:0];
               t_in       = req_tdata[PROC_FW+TYPE_FW-1:PROC_FW];
               amt_in     = req_tdata[PROC_FW+TYPE_FW+AMT_FW-1:PROC_FW+TYPE_FW];
               granted_in = 1'b0;
               found_in   = 1'b0;
               err_in     = 1'b0;
               slot_in    = '0;
               wproc_in   = '0;
               wamt_in    = '0;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_EMIT;
            unique case (cmd_ff)
               CMD_SET_COUNT: begin
                  if (t_ok) begin
                     free_we    = 1'b1;
                     free_wdata = COUNT_BITS'((amt_ext > CMAX) ? CMAX : amt_ext);
                  end else begin
                     err_in = 1'b1;
                  end
               end
               CMD_ALLOCATE, CMD_RELEASE, CMD_RELEASE_ALL: begin
                  priority if (!t_ok || !p_ok) begin
                     err_in = 1'b1;
                  end else if (cmd_ff == CMD_RELEASE_ALL) begin
                     cnt_in   = '0;
                     state_in = ST_RALL;
                  end else if (cmd_ff == CMD_ALLOCATE && amt_ff == '0) begin
                     state_in = ST_EMIT;
                  end else if (cmd_ff == CMD_ALLOCATE && free_ext < amt_ext) begin
                     // Not enough free units: look for the lowest empty slot.
                     scan_req.start      = 1'b1;
                     scan_req.want_valid = 1'b0;
                     state_in            = ST_SCAN;
                  end else begin
                     state_in = ST_HELD;
                  end
               end
               CMD_PICK_WAITER: begin
                  if (t_ok) begin
                     scan_req.start      = 1'b1;
                     scan_req.want_valid = 1'b1;
                     start_slot          = slot_next(cur_ff[t_ix]);
                     state_in            = ST_SCAN;
                  end else begin
                     err_in = 1'b1;
                  end
               end
               default: begin
                  state_in = ST_EMIT;
               end
            endcase
         end
         ST_HELD: begin
            free_we = 1'b1;
            held_we = 1'b1;
            if (cmd_ff == CMD_ALLOCATE) begin
               granted_in = 1'b1;
               add_a      = held_ext;
               add_b      = amt_ext;
               held_wdata = sat_cnt;
               free_wdata = COUNT_BITS'(free_ext - amt_ext);
            end else begin
               add_a      = free_ext;
               add_b      = rel_ext;
               free_wdata = sat_cnt;
               held_wdata = COUNT_BITS'(held_ext - rel_ext);
               err_in     = amt_ext > held_ext;
            end
            state_in = ST_EMIT;
         end
         ST_SCAN: begin
            if (scan_rsp.done) begin
               state_in = ST_EMIT;
               if (cmd_ff == CMD_ALLOCATE) begin
                  if (scan_rsp.found) begin
                     wv_set  = 1'b1;
                     wait_we = 1'b1;
                  end else begin
                     err_in = 1'b1;
                  end
               end else if (scan_rsp.found) begin
                  found_in = 1'b1;
                  slot_in  = hit_slot;
                  cur_we   = 1'b1;
                  state_in = ST_PICK;
               end
            end
         end
         ST_PICK: begin
            wproc_in = wproc_rd_ff[slot_ff];
            wamt_in  = wamt_rd_ff[slot_ff];
            state_in = ST_EMIT;
         end
         ST_RALL: begin
            // Reads for one type go out while the previous type is written back.
            if (int'(cnt_ff) < NUM_TYPES) begin
               held_raddr = held_addr(p_ix, TYPE_W'(cnt_ff));
               row_raddr  = TYPE_W'(cnt_ff);
            end
            if (cnt_ff != '0) begin
               add_a      = SUM_W'(free_ff[prev_ix]);
               add_b      = held_ext;
               free_we    = 1'b1;
               free_waddr = prev_ix;
               held_we    = 1'b1;
               held_waddr = held_addr(p_ix, prev_ix);
               wv_clr     = 1'b1;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_TYPES)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         free_ff      <= '{default: '0};
         wv_ff        <= '{default: '0};
         cur_ff       <= '{default: '0};
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (free_we) begin
            free_ff[free_waddr] <= free_wdata;
         end
         if (wv_set) begin
            wv_ff[t_ix][hit_slot] <= 1'b1;
         end
         if (wv_clr) begin
            wv_ff[prev_ix] <= wv_ff[prev_ix] & ~clr_mask;
         end
         if (cur_we) begin
            cur_ff[t_ix] <= slot_next(hit_slot);
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      p_ff       <= p_in;
      t_ff       <= t_in;
      amt_ff     <= amt_in;
      granted_ff <= granted_in;
      found_ff   <= found_in;
      err_ff     <= err_in;
      slot_ff    <= slot_in;
      wproc_ff   <= wproc_in;
      wamt_ff    <= wamt_in;
      cnt_ff     <= cnt_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (held_we) begin
         held_mem[held_waddr] <= held_wdata;
      end
      held_rd_ff <= held_mem[held_raddr];
   end

   always_ff @(posedge clock) begin
      if (wait_we) begin
         wproc_mem[t_ix][hit_slot] <= p_ff;
         wamt_mem[t_ix][hit_slot]  <= amt_ff;
      end
      wproc_rd_ff <= wproc_mem[row_raddr];
      wamt_rd_ff  <= wamt_mem[row_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`include "resource_allocator_with_wait_lists_assert.svh"

   `RAWL_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready,
      "block still ready in the cycle after accepting a transaction")
   `RAWL_ASSERT_NOW(a_scan_done_in_scan, scan_rsp.done, state_ff == ST_SCAN,
      "slot scanner finished outside the scan state")
   `RAWL_ASSERT_NOW(a_grant_not_error, rsp_valid_ff, !(rsp_data_ff[0] && rsp_data_ff[18]),
      "response flags both a grant and an error")

endmodule

>>> rtl/core/rawl_scan.sv
// Round-robin slot scanner that tests one wait-list slot per cycle.
module rawl_scan #(
   parameter int NUM_SLOTS = rawl_pkg::NUM_PROCS_DEF,
   parameter int SLOT_W    = $clog2(rawl_pkg::NUM_PROCS_DEF)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rawl_pkg::scan_req_type scan_req,
   input  logic [SLOT_W-1:0]      start_slot,
   input  logic [NUM_SLOTS-1:0]   valid_row,
   output rawl_pkg::scan_rsp_type scan_rsp,
   output logic [SLOT_W-1:0]      hit_slot
);
   import rawl_pkg::*;

   localparam int LEFT_W = $clog2(NUM_SLOTS + 1);

   logic              busy_ff, busy_in;
   logic              want_ff, want_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic              hit;

   always_comb begin
      busy_in  = busy_ff;
      want_in  = want_ff;
      idx_in   = idx_ff;
      left_in  = left_ff;
      scan_rsp = '0;
      hit_slot = idx_ff;
      hit      = busy_ff && (valid_row[idx_ff] == want_ff);
      if (busy_ff) begin
         if (hit || (left_ff == LEFT_W'(1))) begin
            scan_rsp.done  = 1'b1;
            scan_rsp.found = hit;
            busy_in        = 1'b0;
         end else begin
            idx_in  = (idx_ff == SLOT_W'(NUM_SLOTS - 1)) ? '0 : idx_ff + 1'b1;
            left_in = left_ff - 1'b1;
         end
      end else if (scan_req.start) begin
         busy_in = 1'b1;
         want_in = scan_req.want_valid;
         idx_in  = start_slot;
         left_in = LEFT_W'(NUM_SLOTS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      want_ff <= want_in;
      idx_ff  <= idx_in;
      left_ff <= left_in;
   end

endmodule
